[rtl/msfd_pkg.sv]
// Shared types, constants and sine table for the modulated stereo feedback delay.
package msfd_pkg;

	// Store geometry; the depth is a power of two so the tap wraps by masking
	localparam int STORE_DEPTH  = 131072;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int SAMPLE_BITS  = 24;
	localparam int TDATA_W      = 2 * SAMPLE_BITS;

	// LFO and sine table
	localparam int PHASE_W      = 32;
	localparam int SINE_ENTRIES = 1024;
	localparam int SINE_W       = $clog2(SINE_ENTRIES);
	localparam int QTR          = SINE_ENTRIES / 4;
	localparam int QTR_W        = SINE_W - 2;
	localparam int SIN_A        = 51472;
	localparam int SIN_B        = 21024;
	localparam int SIN_C        = 2320;
	localparam int SINE_BITS    = 16;

	// Register field widths
	localparam int DELAY_W      = 17;
	localparam int SCAN_W       = 10;
	localparam int DEPTH_W      = 13;
	localparam int GAIN_W       = 16;
	localparam int WET_W        = 17;
	localparam int SHIFT_W      = DEPTH_W + 1;

	// Gain limits
	localparam int FEEDBACK_MAX = 62259;
	localparam int WET_ONE      = 65536;

	// APB address width: seven word registers
	localparam int REG_ADDR_W   = 5;

	typedef struct packed {
		logic [DELAY_W-1:0] delay_samples;
		logic [SCAN_W-1:0]  scan_offset;
		logic [DEPTH_W-1:0] mod_depth;
		logic [PHASE_W-1:0] phase_step;
		logic [GAIN_W-1:0]  feedback_gain;
		logic [WET_W-1:0]   wet_mix;
		logic               mono_input;
	} cfg_t;

	// One strobe per sequencer step
	typedef struct packed {
		logic accept;
		logic lookup;
		logic scale;
		logic addr;
		logic read;
		logic mul;
		logic wb;
	} cmd_t;

	typedef logic [SINE_BITS-1:0] sine_qtr_t [QTR];

	// Quarter-wave magnitudes, Q15, worked out at elaboration
	function automatic sine_qtr_t build_sine_qtr();
		sine_qtr_t tab;
		int k;
		int z;
		int z2;
		int t;
		int r;
		for (k = 0; k < QTR; k++) begin
			z  = k * (65536 / SINE_ENTRIES) * 2;
			z2 = (z * z) / 32768;
			t  = (SIN_C * z2) / 32768;
			t  = SIN_B - t;
			t  = (t * z2) / 32768;
			t  = SIN_A - t;
			r  = (z * t) / 32768;
			if (r > 32767) begin
				r = 32767;
			end
			tab[k] = SINE_BITS'(r);
		end
		return tab;
	endfunction

	localparam sine_qtr_t SINE_QTR = build_sine_qtr();

	// Full-wave lookup by folding; the peaks read +32767 and -32768
	function automatic logic signed [SINE_BITS-1:0] sine_lookup(input logic [SINE_W-1:0] idx);
		logic [QTR_W:0]               k;
		logic [SINE_BITS-1:0]         mag;
		logic signed [SINE_BITS-1:0]  s;
		logic                         neg;
		neg = idx[SINE_W-1];
		if (idx[SINE_W-2]) begin
			k = (QTR_W+1)'(QTR) - {1'b0, idx[QTR_W-1:0]};
		end else begin
			k = {1'b0, idx[QTR_W-1:0]};
		end
		mag = SINE_QTR[k[QTR_W-1:0]];
		if (k[QTR_W]) begin
			s = neg ? {1'b1, {(SINE_BITS-1){1'b0}}} : {1'b0, {(SINE_BITS-1){1'b1}}};
		end else begin
			s = neg ? -$signed(mag) : $signed(mag);
		end
		return s;
	endfunction

	// Clamp a widened sum to the signed sample range
	function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic [SAMPLE_BITS+2:0] v);
		logic [SAMPLE_BITS-1:0] res;
		if ((&v[SAMPLE_BITS+2:SAMPLE_BITS-1]) || !(|v[SAMPLE_BITS+2:SAMPLE_BITS-1])) begin
			res = v[SAMPLE_BITS-1:0];
		end else if (v[SAMPLE_BITS+2]) begin
			res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		return res;
	endfunction

endpackage

[rtl/msfd_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
module msfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/msfd_regs.sv]
// APB configuration registers of the delay.
module msfd_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [msfd_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output msfd_pkg::cfg_t                 cfg
);

	typedef enum logic [2:0] {
		REG_DELAY    = 3'd0,
		REG_SCAN     = 3'd1,
		REG_DEPTH    = 3'd2,
		REG_STEP     = 3'd3,
		REG_FEEDBACK = 3'd4,
		REG_WET      = 3'd5,
		REG_MONO     = 3'd6
	} reg_idx_t;

	logic [2:0]     idx;
	logic           wr_en;
	msfd_pkg::cfg_t cfg_q;

	assign idx    = paddr[msfd_pkg::REG_ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes; unused indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_samples <= msfd_pkg::DELAY_W'(24000);
			cfg_q.scan_offset   <= msfd_pkg::SCAN_W'(500);
			cfg_q.mod_depth     <= '0;
			cfg_q.phase_step    <= msfd_pkg::PHASE_W'(22369);
			cfg_q.feedback_gain <= msfd_pkg::GAIN_W'(26214);
			cfg_q.wet_mix       <= msfd_pkg::WET_W'(32768);
			cfg_q.mono_input    <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_DELAY:    cfg_q.delay_samples <= pwdata[msfd_pkg::DELAY_W-1:0];
				REG_SCAN:     cfg_q.scan_offset   <= pwdata[msfd_pkg::SCAN_W-1:0];
				REG_DEPTH:    cfg_q.mod_depth     <= pwdata[msfd_pkg::DEPTH_W-1:0];
				REG_STEP:     cfg_q.phase_step    <= pwdata[msfd_pkg::PHASE_W-1:0];
				REG_FEEDBACK: cfg_q.feedback_gain <= pwdata[msfd_pkg::GAIN_W-1:0];
				REG_WET:      cfg_q.wet_mix       <= pwdata[msfd_pkg::WET_W-1:0];
				REG_MONO:     cfg_q.mono_input    <= pwdata[0];
				default:      ;
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		unique case (idx)
			REG_DELAY:    prdata = 32'(cfg_q.delay_samples);
			REG_SCAN:     prdata = 32'(cfg_q.scan_offset);
			REG_DEPTH:    prdata = 32'(cfg_q.mod_depth);
			REG_STEP:     prdata = 32'(cfg_q.phase_step);
			REG_FEEDBACK: prdata = 32'(cfg_q.feedback_gain);
			REG_WET:      prdata = 32'(cfg_q.wet_mix);
			REG_MONO:     prdata = 32'(cfg_q.mono_input);
			default:      prdata = '0;
		endcase
	end

endmodule

[rtl/msfd_ctrl.sv]
// Sequencer for one stereo item and the output handshake.
module msfd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output msfd_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_LOOKUP = 7'b0000010,
		S_SCALE  = 7'b0000100,
		S_ADDR   = 7'b0001000,
		S_READ   = 7'b0010000,
		S_MUL    = 7'b0100000,
		S_WB     = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;
	logic   out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	// Step strobes
	assign cmd.accept = s_tvalid && (state_q == S_IDLE);
	assign cmd.lookup = (state_q == S_LOOKUP);
	assign cmd.scale  = (state_q == S_SCALE);
	assign cmd.addr   = (state_q == S_ADDR);
	assign cmd.read   = (state_q == S_READ);
	assign cmd.mul    = (state_q == S_MUL);
	assign cmd.wb     = (state_q == S_WB) && out_free;

	// Next state
	always_comb begin
		unique case (state_q)
			S_IDLE:   state_n = s_tvalid ? S_LOOKUP : S_IDLE;
			S_LOOKUP: state_n = S_SCALE;
			S_SCALE:  state_n = S_ADDR;
			S_ADDR:   state_n = S_READ;
			S_READ:   state_n = S_MUL;
			S_MUL:    state_n = S_WB;
			S_WB:     state_n = out_free ? S_IDLE : S_WB;
			default:  state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.wb) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/msfd_dp.sv]
// Datapath: LFO, tap address, delay stores, feedback and dry/wet mix.
module msfd_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  msfd_pkg::cmd_t                cmd,
	input  msfd_pkg::cfg_t                cfg,
	input  logic [msfd_pkg::TDATA_W-1:0]  in_data,
	output logic [msfd_pkg::TDATA_W-1:0]  out_data
);

	localparam int SB     = msfd_pkg::SAMPLE_BITS;
	localparam int AW     = msfd_pkg::ADDR_W;
	localparam int FBP_W  = SB + msfd_pkg::GAIN_W + 1;
	localparam int MIXP_W = SB + msfd_pkg::WET_W + 1;
	localparam int MOD_W  = msfd_pkg::SINE_BITS + msfd_pkg::SHIFT_W;

	// Control state
	logic [msfd_pkg::PHASE_W-1:0] phase_q;
	logic [AW-1:0]                wr_q;
	logic                         wrapped_q;

	// Item payload
	logic signed [SB-1:0]                  l_q;
	logic signed [SB-1:0]                  r_q;
	logic signed [msfd_pkg::SINE_BITS-1:0] sin_q;
	logic signed [msfd_pkg::SHIFT_W-1:0]   shift_q;
	logic [AW-1:0]                         base_q;
	logic [AW-1:0]                         rd_q;
	logic                                  hit_q;
	logic [msfd_pkg::GAIN_W-1:0]           fb_q;
	logic [msfd_pkg::WET_W-1:0]            wet_q;
	logic [msfd_pkg::WET_W-1:0]            dry_q;
	logic signed [FBP_W-1:0]               fbp_l_q;
	logic signed [FBP_W-1:0]               fbp_r_q;
	logic signed [MIXP_W-1:0]              wetp_l_q;
	logic signed [MIXP_W-1:0]              wetp_r_q;
	logic signed [MIXP_W-1:0]              dryp_l_q;
	logic signed [MIXP_W-1:0]              dryp_r_q;
	logic [msfd_pkg::TDATA_W-1:0]          out_q;

	// Combinational
	logic signed [MOD_W-1:0]   mod_prod;
	logic signed [MOD_W-1:0]   mod_adj;
	logic [31:0]               base_full;
	logic [31:0]               rd_full;
	logic [AW-1:0]             rd_n;
	logic [msfd_pkg::WET_W-1:0] wet_eff;
	logic [2*SB-1:0]           ram_rdata;
	logic signed [SB-1:0]      dl;
	logic signed [SB-1:0]      dr;
	logic [SB-1:0]             st_l;
	logic [SB-1:0]             st_r;
	logic [SB-1:0]             mix_l;
	logic [SB-1:0]             mix_r;

	// Tap shift: sine times depth, divided by 32768 toward zero
	assign mod_prod = sin_q * $signed({1'b0, cfg.mod_depth});
	assign mod_adj  = mod_prod + (mod_prod[MOD_W-1] ? MOD_W'(32767) : MOD_W'(0));

	// Base tap behind the write slot; the power-of-two depth wraps by masking
	assign base_full = 32'(wr_q) - 32'(cfg.delay_samples) - 32'(cfg.scan_offset);
	assign rd_full   = 32'(base_q) + {{(32-msfd_pkg::SHIFT_W){shift_q[msfd_pkg::SHIFT_W-1]}},
		shift_q};
	assign rd_n      = rd_full[AW-1:0];

	assign wet_eff = (cfg.wet_mix > msfd_pkg::WET_W'(msfd_pkg::WET_ONE)) ?
		msfd_pkg::WET_W'(msfd_pkg::WET_ONE) : cfg.wet_mix;

	// Entries not yet written since reset read as zero
	assign dl = hit_q ? $signed(ram_rdata[SB-1:0]) : '0;
	assign dr = hit_q ? $signed(ram_rdata[2*SB-1:SB]) : '0;

	// Feedback store value and mix, products divided by 65536 toward zero
	always_comb begin
		logic signed [FBP_W-1:0]  fa_l;
		logic signed [FBP_W-1:0]  fa_r;
		logic signed [MIXP_W:0]   ms_l;
		logic signed [MIXP_W:0]   ms_r;
		logic signed [MIXP_W:0]   ma_l;
		logic signed [MIXP_W:0]   ma_r;
		logic signed [SB+1:0]     sum_l;
		logic signed [SB+1:0]     sum_r;
		fa_l  = fbp_l_q + (fbp_l_q[FBP_W-1] ? FBP_W'(65535) : FBP_W'(0));
		fa_r  = fbp_r_q + (fbp_r_q[FBP_W-1] ? FBP_W'(65535) : FBP_W'(0));
		sum_l = {{2{l_q[SB-1]}}, l_q} + {fa_l[FBP_W-1], fa_l[FBP_W-1:16]};
		sum_r = {{2{r_q[SB-1]}}, r_q} + {fa_r[FBP_W-1], fa_r[FBP_W-1:16]};
		st_l  = msfd_pkg::sat_sample({sum_l[SB+1], sum_l});
		st_r  = msfd_pkg::sat_sample({sum_r[SB+1], sum_r});
		ms_l  = {dryp_l_q[MIXP_W-1], dryp_l_q} + {wetp_l_q[MIXP_W-1], wetp_l_q};
		ms_r  = {dryp_r_q[MIXP_W-1], dryp_r_q} + {wetp_r_q[MIXP_W-1], wetp_r_q};
		ma_l  = ms_l + (ms_l[MIXP_W] ? (MIXP_W+1)'(65535) : (MIXP_W+1)'(0));
		ma_r  = ms_r + (ms_r[MIXP_W] ? (MIXP_W+1)'(65535) : (MIXP_W+1)'(0));
		mix_l = msfd_pkg::sat_sample(ma_l[MIXP_W:16]);
		mix_r = msfd_pkg::sat_sample(ma_r[MIXP_W:16]);
	end

	// Write slot, fill marker and LFO phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			wr_q      <= '0;
			wrapped_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				phase_q <= phase_q + cfg.phase_step;
			end
			if (cmd.wb) begin
				wr_q <= wr_q + AW'(1);
				if (&wr_q) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	// Per-item payload steps
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			l_q <= in_data[SB-1:0];
			r_q <= cfg.mono_input ? in_data[SB-1:0] : in_data[2*SB-1:SB];
		end
		if (cmd.lookup) begin
			sin_q <= msfd_pkg::sine_lookup(
				phase_q[msfd_pkg::PHASE_W-1 -: msfd_pkg::SINE_W]);
		end
		if (cmd.scale) begin
			shift_q <= mod_adj[MOD_W-2 -: msfd_pkg::SHIFT_W];
			base_q  <= base_full[AW-1:0];
			fb_q    <= (cfg.feedback_gain > msfd_pkg::GAIN_W'(msfd_pkg::FEEDBACK_MAX)) ?
				msfd_pkg::GAIN_W'(msfd_pkg::FEEDBACK_MAX) : cfg.feedback_gain;
			wet_q   <= wet_eff;
			dry_q   <= msfd_pkg::WET_W'(msfd_pkg::WET_ONE) - wet_eff;
		end
		if (cmd.addr) begin
			rd_q  <= rd_n;
			hit_q <= wrapped_q || (rd_n < wr_q);
		end
		if (cmd.mul) begin
			fbp_l_q  <= dl * $signed({1'b0, fb_q});
			fbp_r_q  <= dr * $signed({1'b0, fb_q});
			wetp_l_q <= dl * $signed({1'b0, wet_q});
			wetp_r_q <= dr * $signed({1'b0, wet_q});
			dryp_l_q <= l_q * $signed({1'b0, dry_q});
			dryp_r_q <= r_q * $signed({1'b0, dry_q});
		end
		if (cmd.wb) begin
			out_q <= {mix_r, mix_l};
		end
	end

	assign out_data = out_q;

	// Both channels share one store word: right above left
	msfd_ram #(
		.WIDTH (2 * SB),
		.DEPTH (msfd_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.wb),
		.waddr (wr_q),
		.wdata ({st_r, st_l}),
		.re    (cmd.read),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

endmodule

[rtl/modulated_stereo_feedback_delay.sv]
// Top level of the modulated stereo feedback delay.
// Each stereo item occupies the sequencer through its steps: accept, sine lookup, tap
// scaling, tap address, store read, gain multiply and write-back, stepped over one shared
// store RAM port pair; its result is loaded into the output register in the write-back
// step, which waits while an earlier result is still unread. A new item is taken once the
// sequencer is back in idle, so the block works on one item at a time. The result waits
// in the output register, so the next item is accepted while it is still unread. No clearing
// pass runs after reset: the write pointer and a wrap flag mark which store entries
// have been written, and unwritten entries read as zero.
module modulated_stereo_feedback_delay (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [msfd_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [msfd_pkg::TDATA_W-1:0]    s_tdata,  // left_in, right_in
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [msfd_pkg::TDATA_W-1:0]    m_tdata   // left_out, right_out
);

	msfd_pkg::cfg_t cfg;
	msfd_pkg::cmd_t cmd;

	msfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	msfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	msfd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.in_data  (s_tdata),
		.out_data (m_tdata)
	);

endmodule

[rtl/msfd_checker.sv]
// Port-level checks for the delay, bound to the top level.
module msfd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [msfd_pkg::REG_ADDR_W-1:0] paddr,
	input logic [31:0]                     pwdata,
	input logic [31:0]                     prdata,
	input logic                            pready,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [msfd_pkg::TDATA_W-1:0]    m_tdata
);

	// A waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// One item at a time: no second accept right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready straight after an accepted item");

	// Delay register reads back what was written
	a_delay_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr == '0) ##1
		(psel && penable && !pwrite && paddr == '0)
		|-> prdata[msfd_pkg::DELAY_W-1:0] == $past(pwdata[msfd_pkg::DELAY_W-1:0]))
		else $error("delay register read-back mismatch");

endmodule

bind modulated_stereo_feedback_delay msfd_checker u_msfd_checker (.*);

[sim/tb_top.sv]
// Self-checking testbench for the modulated stereo feedback delay.
`timescale 1ns / 1ps

module tb_top;

	localparam int STORE_LEN       = msfd_pkg::STORE_DEPTH;
	localparam int SINE_LEN        = msfd_pkg::SINE_ENTRIES;
	localparam int POLY_A          = 51472;
	localparam int POLY_B          = 21024;
	localparam int POLY_C          = 2320;
	localparam int FB_CEIL         = 62259;
	localparam int WET_FULL        = 65536;
	localparam int PAIRS_PER_PHASE = 204;
	localparam int RANDOM_PHASES   = 8;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int TAIL_CYCLES     = 20;

	// Register indexes; the last one is past the register list and must be ignored
	typedef enum int {
		R_DELAY,
		R_SCAN,
		R_DEPTH,
		R_STEP,
		R_FEEDBACK,
		R_WET,
		R_MONO,
		R_UNUSED
	} reg_e;

	// Scoreboard: own model of the delay line plus the queue of mixed pairs still due
	class mix_scoreboard;
		int                 sine_q15 [SINE_LEN];
		logic signed [23:0] left_line [STORE_LEN];
		logic signed [23:0] right_line [STORE_LEN];
		int                 wr_ptr;
		logic [31:0]        lfo;
		int                 delay_r;
		int                 scan_r;
		int                 depth_r;
		logic [31:0]        step_r;
		int                 fb_r;
		int                 wet_r;
		bit                 mono_r;
		logic [47:0]        pending_mix [$];
		int                 pairs_in;
		int                 pairs_out;
		int                 mismatches;

		function new();
			longint u;
			longint z;
			longint z2;
			longint t;
			longint s;
			// quarter-wave folded polynomial sine, Q15, capped at +32767
			for (int i = 0; i < SINE_LEN; i++) begin
				u = (longint'(i) * 65536) / SINE_LEN;
				if (u < 16384) begin
					z = u * 2;
				end else if (u < 49152) begin
					z = (32768 - u) * 2;
				end else begin
					z = (u - 65536) * 2;
				end
				z2 = (z * z) / 32768;
				t  = (POLY_C * z2) / 32768;
				t  = POLY_B - t;
				t  = (t * z2) / 32768;
				t  = POLY_A - t;
				s  = (z * t) / 32768;
				if (s > 32767) begin
					s = 32767;
				end
				if (s < -32768) begin
					s = -32768;
				end
				sine_q15[i] = int'(s);
			end
			foreach (left_line[k]) begin
				left_line[k]  = '0;
				right_line[k] = '0;
			end
			wr_ptr     = 0;
			lfo        = '0;
			delay_r    = 24000;
			scan_r     = 500;
			depth_r    = 0;
			step_r     = 32'd22369;
			fb_r       = 26214;
			wet_r      = 32768;
			mono_r     = 1'b0;
			pairs_in   = 0;
			pairs_out  = 0;
			mismatches = 0;
		endfunction

		function automatic logic [23:0] clamp24(longint v);
			if (v > 64'sd8388607) begin
				return 24'h7FFFFF;
			end
			if (v < -64'sd8388608) begin
				return 24'h800000;
			end
			return v[23:0];
		endfunction

		function void set_reg(reg_e idx, logic [31:0] v);
			case (idx)
				R_DELAY:    delay_r = int'(v[16:0]);
				R_SCAN:     scan_r  = int'(v[9:0]);
				R_DEPTH:    depth_r = int'(v[12:0]);
				R_STEP:     step_r  = v;
				R_FEEDBACK: fb_r    = int'(v[15:0]);
				R_WET:      wet_r   = int'(v[16:0]);
				R_MONO:     mono_r  = v[0];
				default:    ;
			endcase
		endfunction

		// One accepted stereo item: advance the LFO, read the taps, write back, mix
		function void note_pair(logic [47:0] d);
			longint      l;
			longint      r;
			longint      dl;
			longint      dr;
			longint      fb;
			longint      wet;
			longint      dry;
			longint      shift;
			longint      pos;
			int          rd;
			logic [23:0] out_l;
			logic [23:0] out_r;
			pairs_in++;
			l   = longint'($signed(d[23:0]));
			r   = mono_r ? l : longint'($signed(d[47:24]));
			fb  = (fb_r > FB_CEIL) ? FB_CEIL : fb_r;
			wet = (wet_r > WET_FULL) ? WET_FULL : wet_r;
			dry = WET_FULL - wet;

			lfo   = lfo + step_r;
			shift = (longint'(sine_q15[lfo[31:22]]) * longint'(depth_r)) / 32768;
			pos   = longint'(wr_ptr) - delay_r - scan_r + shift;
			rd    = int'(pos & (STORE_LEN - 1));

			// taps are read before the write, so a tap on the write slot sees old data
			dl = left_line[rd];
			dr = right_line[rd];
			left_line[wr_ptr]  = clamp24(l + (dl * fb) / 65536);
			right_line[wr_ptr] = clamp24(r + (dr * fb) / 65536);

			out_l = clamp24((l * dry + dl * wet) / 65536);
			out_r = clamp24((r * dry + dr * wet) / 65536);
			pending_mix.push_back({out_r, out_l});
			wr_ptr = (wr_ptr + 1) % STORE_LEN;
		endfunction

		function void check_mix(logic [47:0] d);
			logic [47:0] want;
			pairs_out++;
			if (pending_mix.size() == 0) begin
				mismatches++;
				$display("%0t: output pair with none expected, got left %0d right %0d",
					$time, $signed(d[23:0]), $signed(d[47:24]));
				return;
			end
			want = pending_mix.pop_front();
			if (d[23:0] !== want[23:0]) begin
				mismatches++;
				$display("%0t: left_out expected %0d got %0d",
					$time, $signed(want[23:0]), $signed(d[23:0]));
			end
			if (d[47:24] !== want[47:24]) begin
				mismatches++;
				$display("%0t: right_out expected %0d got %0d",
					$time, $signed(want[47:24]), $signed(d[47:24]));
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [msfd_pkg::REG_ADDR_W-1:0] paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [msfd_pkg::TDATA_W-1:0]    s_tdata;  // left_in, right_in
	logic                            m_tvalid;
	logic                            m_tready;
	logic [msfd_pkg::TDATA_W-1:0]    m_tdata;  // left_out, right_out

	mix_scoreboard sb;
	int            send_idle_pct = 0;
	int            stall_pct = 0;
	int            hold_cycles = 0;
	int            settings_used = 0;

	modulated_stereo_feedback_delay u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor: every accepted item feeds the model, every taken result is checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_pair(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				sb.check_mix(m_tdata);
			end
		end
	end

	// Receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles = hold_cycles - 1;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Watchdog on cycles without any accepted item, taken result or register access
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("FAIL");
		$finish;
	end

	// APB write; psel stays up so writes can run back to back
	task automatic apb_write(input reg_e idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= msfd_pkg::REG_ADDR_W'(int'(idx) * 4);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
	endtask

	// Full register set, plus a stray write past the last register
	task automatic program_regs(input int dly, input int scn, input int dep,
			input logic [31:0] stp, input int fbk, input int wt, input bit mn);
		apb_write(R_DELAY, 32'(dly));
		apb_write(R_SCAN, 32'(scn));
		apb_write(R_DEPTH, 32'(dep));
		apb_write(R_STEP, stp);
		apb_write(R_FEEDBACK, 32'(fbk));
		apb_write(R_WET, 32'(wt));
		apb_write(R_MONO, 32'(mn));
		apb_write(R_UNUSED, $urandom);
		psel    <= 1'b0;
		penable <= 1'b0;
		settings_used++;
	endtask

	task automatic send_pair(input logic [23:0] l, input logic [23:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r, l};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering and wait for every due result
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_mix.size() != 0);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			1:       begin send_idle_pct = 56; stall_pct = 0;  end
			2:       begin send_idle_pct = 0;  stall_pct = 56; end
			3:       begin send_idle_pct = 24; stall_pct = 24; end
			default: begin send_idle_pct = 0;  stall_pct = 0;  end
		endcase
	endtask

	// Mostly full-range samples, with rails and small values mixed in
	function automatic logic [23:0] pick_sample();
		logic [31:0] rnd;
		rnd = $urandom;
		case ($urandom_range(9))
			0:       return 24'h7FFFFF;
			1:       return 24'h800000;
			2:       return {{15{rnd[8]}}, rnd[8:0]};
			default: return rnd[23:0];
		endcase
	endfunction

	initial begin
		int          dly;
		int          scn;
		int          dep;
		int          fbk;
		int          wt;
		bit          mn;
		logic [31:0] stp;

		sb = new();
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(0);

		// reset settings: rails and sign extremes into half wet
		send_pair(24'h7FFFFF, 24'h800000);
		send_pair(24'h800000, 24'h7FFFFF);
		send_pair(24'h000000, 24'h000000);
		send_pair(24'hFFFFFF, 24'h000001);
		drain();

		// tap on the write slot, gains above their limits, mono
		program_regs(0, 0, 0, 32'hFFFF_FFFF, 65535, 131071, 1'b1);
		send_pair(24'h7FFFFF, 24'h000123);
		send_pair(24'h800000, 24'h000000);
		send_pair(24'h555555, 24'hAAAAAA);
		drain();

		// one-sample delay at the feedback limit: the stores run into saturation
		program_regs(1, 0, 0, 32'd0, FB_CEIL, WET_FULL, 1'b0);
		repeat (4) send_pair(24'h7FFFFF, 24'h800000);
		repeat (2) send_pair(24'h800000, 24'h7FFFFF);
		drain();

		// quarter-turn LFO steps through both sine peaks
		program_regs(8, 0, 4, 32'h4000_0000, 30000, 40000, 1'b0);
		repeat (6) send_pair(pick_sample(), pick_sample());

		// random settings; the first two are all-zero and all-ones registers
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			if (ph == 0) begin
				program_regs(0, 0, 0, 32'd0, 0, 0, 1'b0);
			end else if (ph == 1) begin
				program_regs(131071, 1023, 8191, 32'hFFFF_FFFF, 65535, 131071, 1'b1);
			end else begin
				case ($urandom_range(3))
					0:       dly = $urandom_range(0, 16);
					1:       dly = $urandom_range(17, 400);
					2:       dly = $urandom_range(0, 2047);
					default: dly = $urandom_range(0, 131071);
				endcase
				scn = ($urandom_range(3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 20);
				dep = ($urandom_range(3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 40);
				stp = ($urandom_range(1) == 0) ? $urandom : $urandom_range(0, 1 << 24);
				fbk = ($urandom_range(3) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, FB_CEIL);
				wt  = ($urandom_range(3) == 0) ? $urandom_range(0, 131071)
					: $urandom_range(0, WET_FULL);
				mn  = $urandom_range(1);
				program_regs(dly, scn, dep, stp, fbk, wt, mn);
			end
			set_idling(ph % 4);
			// long receiver hold-off while items keep coming, so the input backs up
			if (ph == 4) begin
				hold_cycles = HOLD_OFF_CYCLES;
			end
			for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
				if (ph == 5 && n == PAIRS_PER_PHASE / 2) begin
					drain();
				end
				send_pair(pick_sample(), pick_sample());
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending_mix.size() != 0) begin
			$display("%0t: %0d expected pair(s) never arrived", $time, sb.pending_mix.size());
		end
		$display("Run covered %0d stereo items and %0d results over %0d register settings,",
			sb.pairs_in, sb.pairs_out, settings_used);
		$display("including rails, saturation, a tap on the write slot and idle/stall mixes.");
		if (sb.mismatches == 0 && sb.pending_mix.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
